@@ hw/rtl/orma_pkg.sv @@
// Shared constants and controller/datapath types for the ring moving average.
`default_nettype none

package orma_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int WIN_W     = 9;
   localparam int COUNT_W   = 9;
   localparam int MEAN_W    = 40;
   localparam int FRAC_W    = 8;
   localparam int DEPTH_DEF = 256;

   localparam logic [WIN_W-1:0] WIN_RESET = 9'd256;

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic capture;   // latch request, read oldest slot
      logic update;    // ring, index and running sum update
      logic setup;     // load divider operands
      logic step;      // one divider iteration
      logic load;      // move result into output register
   } orma_cmd_type;

   typedef struct packed {
      logic div_last;
   } orma_sts_type;

endpackage

`default_nettype wire

@@ hw/rtl/orma_req_if.sv @@
// Request channel: command and sample with valid/ready.
`default_nettype none

interface orma_req_if;
   import orma_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       command;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output command, output sample, input ready);
   modport sink   (input valid, input command, input sample, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/orma_rsp_if.sv @@
// Response channel: count, flags and mean with valid/ready.
`default_nettype none

interface orma_rsp_if;
   import orma_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [COUNT_W-1:0]       count;
   logic                     is_full;
   logic                     is_empty;
   logic signed [MEAN_W-1:0] mean;

   modport source (output valid, output count, output is_full, output is_empty,
                   output mean, input ready);
   modport sink   (input valid, input count, input is_full, input is_empty,
                   input mean, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/orma_ctrl.sv @@
// Sequencer for the ring moving average: handshakes and datapath commands.
`default_nettype none

module orma_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output orma_pkg::orma_cmd_type cmd,
   input  orma_pkg::orma_sts_type sts
);
   import orma_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPDATE = 3'd1;
   localparam logic [2:0] ST_SETUP  = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_LOAD   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // wait here while the previous result is still pending
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.update, cmd.setup, cmd.step, cmd.load}))
      else $error("more than one datapath command at once");

   a_capture_then_update: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.update)
      else $error("captured request not followed by update");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending response overwritten");

   a_rsp_drop_on_take: assert property (@(posedge clock) disable iff (reset)
      ($fell(rsp_valid_ff) && !$past(reset)) |-> $past(rsp_ready))
      else $error("response withdrawn without handshake");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/orma_dp.sv @@
// Datapath: sample ring, running sum, serial divider and response register.
`default_nettype none

module orma_dp #(
   parameter int DEPTH = orma_pkg::DEPTH_DEF
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  orma_pkg::orma_cmd_type                  cmd,
   output orma_pkg::orma_sts_type                  sts,
   input  wire                                     req_command,
   input  wire signed [orma_pkg::SAMPLE_W-1:0]     req_sample,
   input  wire                                     csr_we,
   input  wire        [orma_pkg::WIN_W-1:0]        csr_wdata,
   output logic       [orma_pkg::COUNT_W-1:0]      out_count,
   output logic                                    out_is_full,
   output logic                                    out_is_empty,
   output logic signed [orma_pkg::MEAN_W-1:0]      out_mean
);
   import orma_pkg::*;

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW  = SAMPLE_W + $clog2(DEPTH);   // running sum width
   localparam int DW  = SW + FRAC_W;                // scaled sum magnitude width
   localparam int STW = $clog2(DW);

   function automatic logic [WIN_W-1:0] eff_len(input logic [WIN_W-1:0] w);
      logic [WIN_W-1:0] r;
      r = w;
      if (w == '0) begin
         r = WIN_W'(1);
      end else if (int'(w) > DEPTH) begin
         r = WIN_W'(DEPTH);
      end
      return r;
   endfunction

   logic [SAMPLE_W-1:0] mem [DEPTH];

   logic [WIN_W-1:0]           len_ff, len_in;
   logic [WIN_W-1:0]           idx_ff, idx_in;
   logic                       full_ff, full_in;
   logic signed [SW-1:0]       sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       cmd_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [COUNT_W-1:0]         count_ff;
   logic                       neg_ff;
   logic [COUNT_W-1:0]         rem_ff, rem_in;
   logic [DW-1:0]              quo_ff, quo_in;
   logic [STW-1:0]             step_ff;

   logic [WIN_W-1:0]     slot, slot_inc;
   logic signed [SW-1:0] old_ext;
   logic signed [DW-1:0] scaled;
   logic [COUNT_W:0]     trial, divisor;
   logic                 ge;
   logic [DW-1:0]        quo_signed;

   assign slot     = (idx_ff >= len_ff) ? '0 : idx_ff;
   assign slot_inc = slot + WIN_W'(1);
   assign old_ext  = full_ff ? SW'(rd_data_ff) : '0;

   // ring state
   always_comb begin
      len_in  = len_ff;
      idx_in  = idx_ff;
      full_in = full_ff;
      sum_in  = sum_ff;
      if (cmd.update) begin
         if (cmd_ff == CMD_CLEAR) begin
            idx_in  = '0;
            full_in = 1'b0;
            sum_in  = '0;
         end else begin
            sum_in = sum_ff - old_ext + SW'(sample_ff);
            if (slot_inc >= len_ff) begin
               idx_in  = '0;
               full_in = 1'b1;
            end else begin
               idx_in = slot_inc;
            end
         end
      end
      if (csr_we) begin
         len_in  = eff_len(csr_wdata);
         idx_in  = '0;
         full_in = 1'b0;
         sum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= eff_len(WIN_RESET);
         idx_ff  <= '0;
         full_ff <= 1'b0;
         sum_ff  <= '0;
      end else begin
         len_ff  <= len_in;
         idx_ff  <= idx_in;
         full_ff <= full_in;
         sum_ff  <= sum_in;
      end
   end

   // sample store; read data is the oldest entry once the ring is full
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[AW'(slot)];
      if (cmd.update && (cmd_ff == CMD_PUSH)) begin
         mem[AW'(slot)] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= req_command;
         sample_ff <= req_sample;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign scaled  = {sum_ff, {FRAC_W{1'b0}}};
   assign divisor = {1'b0, count_ff};
   assign trial   = {rem_ff, quo_ff[DW-1]};
   assign ge      = (trial >= divisor);

   always_comb begin
      rem_in = ge ? COUNT_W'(trial - divisor) : trial[COUNT_W-1:0];
      quo_in = {quo_ff[DW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         count_ff <= full_ff ? len_ff : idx_ff;
         neg_ff   <= sum_ff[SW-1];
         quo_ff   <= sum_ff[SW-1] ? DW'(-scaled) : DW'(scaled);
         rem_ff   <= '0;
         step_ff  <= '0;
      end else if (cmd.step) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + STW'(1);
      end
   end

   assign sts.div_last = (step_ff == STW'(DW - 1));
   assign quo_signed   = neg_ff ? (~quo_ff + DW'(1)) : quo_ff;

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_count    <= count_ff;
         out_is_full  <= full_ff;
         out_is_empty <= (count_ff == '0);
         out_mean     <= (count_ff == '0) ? '0 : MEAN_W'(quo_signed);
      end
   end

`ifndef SYNTH
   a_idx_in_window: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (idx_ff < len_ff))
      else $error("write index outside window");

   a_push_not_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && cmd_ff == CMD_PUSH) |=> (full_ff || idx_ff != '0))
      else $error("ring empty after push");

   a_len_legal: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (len_ff != '0 && int'(len_ff) <= DEPTH))
      else $error("effective window length out of range");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/overwrite_ring_moving_average.sv @@
// Top level of the ring moving average: controller, datapath and channel hookup.
`default_nettype none

// Moving average over the last window_len signed 32-bit samples. A push request
// (command 0) writes its sample into a ring that overwrites the oldest entry once
// full; a clear request (command 1) empties the ring. Each request returns one
// response: sample count, full and empty flags, and the mean times 256 truncated
// toward zero (0 when empty). Writing csr_wdata with csr_we sets the window
// (0 acts as 1, values above DEPTH act as DEPTH) and also empties the ring; write
// it only while no request is in flight. One request is processed at a time: an
// accepted request passes through the ring update, the divider setup, the divider
// steps and the load into the output register, and the next request is taken
// only after that load. The restoring divider produces one of its SUM_W + 8
// quotient bits per cycle, where SUM_W is 32 + clog2(DEPTH). A finished response
// waits in an output register while the next request is taken; that result then
// holds in the divider until the output register is free.
module overwrite_ring_moving_average #(
   parameter int DEPTH = orma_pkg::DEPTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   orma_req_if.sink                     req_bus,
   orma_rsp_if.source                   rsp_bus,
   input  wire                          csr_we,
   input  wire [orma_pkg::WIN_W-1:0]    csr_wdata
);
   import orma_pkg::*;

   orma_cmd_type cmd;
   orma_sts_type sts;

   orma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   orma_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_command  (req_bus.command),
      .req_sample   (req_bus.sample),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .out_count    (rsp_bus.count),
      .out_is_full  (rsp_bus.is_full),
      .out_is_empty (rsp_bus.is_empty),
      .out_mean     (rsp_bus.mean)
   );

endmodule

`default_nettype wire
